FILE: hw/rtl/ttcs_pkg.sv
// Shared types, constants and helper functions for the text terminal writer.
package ttcs_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_WIDTH      = 4;

  localparam int CELL_COUNT   = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int SCROLL_CELLS = CELL_COUNT - SCREEN_COLUMNS;
  localparam int ADDR_W       = $clog2(CELL_COUNT);
  localparam int ROW_W        = $clog2(SCREEN_ROWS + 1);
  localparam int COL_W        = $clog2(SCREEN_COLUMNS);
  localparam int TABC_W       = $clog2(TAB_WIDTH + 1);
  localparam int CELL_W       = 16;

  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_RETURN    = 8'h0D;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0]        STYLE_RESET = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_RESET = {STYLE_RESET, CH_SPACE};

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_SET   = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CK_PRINT,
    CK_NEWLINE,
    CK_RETURN,
    CK_TAB,
    CK_BACKSPACE
  } ch_kind_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LATCH,
    DP_PUT_CHAR,
    DP_PUT_SPACE,
    DP_NEWLINE,
    DP_RETURN,
    DP_TAB_INIT,
    DP_BACKSPACE,
    DP_SET_CURSOR,
    DP_READ_ISSUE,
    DP_READ_CAPTURE,
    DP_CLEAR_INIT,
    DP_SCROLL_INIT,
    DP_SCROLL_COPY,
    DP_SCROLL_END,
    DP_FILL_STYLE
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_RESET_FILL,
    ST_IDLE,
    ST_DISPATCH,
    ST_TAB,
    ST_CHECK,
    ST_SCROLL_COPY,
    ST_SCROLL_BLANK,
    ST_SCROLL_END,
    ST_CLEAR,
    ST_READ_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   reset_fill;
  } dp_cmd_t;

  typedef struct packed {
    op_t      op;
    ch_kind_t ch_kind;
    logic     row_over;
    logic     tab_busy;
    logic     copy_done;
    logic     sweep_last;
  } dp_status_t;

  // Linear cell address of a row and column.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(int'(r) * SCREEN_COLUMNS + int'(c));
  endfunction

  // Number of spaces a tab writes from a given column; a constant lookup.
  function automatic logic [TABC_W-1:0] tab_gap(input logic [COL_W-1:0] c);
    logic [TABC_W-1:0] g;
    g = TABC_W'(TAB_WIDTH);
    for (int k = 0; k < SCREEN_COLUMNS; k++) begin
      if (c == COL_W'(k)) g = TABC_W'(TAB_WIDTH - (k % TAB_WIDTH));
    end
    return g;
  endfunction

endpackage

FILE: hw/rtl/text_terminal_cursor_scroll.sv
// Character-cell terminal writer: a result follows each item, shown with the done strobe;
// a tab writes its spaces one at a time, each checked for wrap and scroll.
// Clear walks the screen store one cell per cycle. A scroll copies each cell up a row
// (one pipelined copy per cell) and then blanks the bottom row, paced by the single
// write port of the store. One item at a time; busy is high until the done strobe passes.
// After reset the store is filled with blanks of style 0x07, with busy high.
module text_terminal_cursor_scroll (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [7:0]  ch,
  input  logic [4:0]  row,
  input  logic [6:0]  col,
  output logic        done,
  output logic [15:0] cell_entry,
  output logic [4:0]  cursor_row_out,
  output logic [6:0]  cursor_col_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  ttcs_pkg::dp_cmd_t    cmd;
  ttcs_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  ttcs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ttcs_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .ch            (ch),
    .row           (row),
    .col           (col),
    .style_we      (cfg_valid && cfg_ready),
    .style_data    (cfg_data),
    .cmd           (cmd),
    .status        (status),
    .cell_entry    (cell_entry),
    .cursor_row_out(cursor_row_out),
    .cursor_col_out(cursor_col_out)
  );

`ifndef NO_ASSERTIONS
  // The result strobe lasts exactly one cycle.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Any pending wrap or scroll is resolved before the result is shown.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((int'(cursor_row_out) < ttcs_pkg::SCREEN_ROWS) &&
              (int'(cursor_col_out) < ttcs_pkg::SCREEN_COLUMNS)))
    else $error("cursor out of range at result");

  // Only a read gives a nonzero cell.
  a_cell_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status.op != ttcs_pkg::OP_READ)) |-> (cell_entry == '0))
    else $error("cell_entry nonzero for an op other than read");
`endif

endmodule

FILE: hw/rtl/ttcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ttcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/ttcs_datapath.sv
// Cursor, style register, sweep counter, output register and screen store.
module ttcs_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           op,
  input  logic [7:0]           ch,
  input  logic [4:0]           row,
  input  logic [6:0]           col,
  input  logic                 style_we,
  input  logic [7:0]           style_data,
  input  ttcs_pkg::dp_cmd_t    cmd,
  output ttcs_pkg::dp_status_t status,
  output logic [15:0]          cell_entry,
  output logic [4:0]           cursor_row_out,
  output logic [6:0]           cursor_col_out
);

  logic [7:0]                     text_style;
  ttcs_pkg::op_t                  op_q;
  logic [7:0]                     ch_q;
  logic [4:0]                     row_q;
  logic [6:0]                     col_q;
  logic [ttcs_pkg::ROW_W-1:0]     cursor_row, cursor_row_next;
  logic [ttcs_pkg::COL_W-1:0]     cursor_col, cursor_col_next;
  logic [ttcs_pkg::ADDR_W-1:0]    sweep, sweep_next;
  logic                           pend, pend_next;
  logic [ttcs_pkg::ADDR_W-1:0]    waddr_d, waddr_d_next;
  logic [ttcs_pkg::TABC_W-1:0]    tab_left, tab_left_next;
  logic [15:0]                    cell_entry_next;

  logic                           ram_we;
  logic [ttcs_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [ttcs_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;
  logic                           in_range;
  logic [ttcs_pkg::ADDR_W-1:0]    cursor_addr, req_addr;
  logic [ttcs_pkg::ROW_W-1:0]     bs_row;
  logic [ttcs_pkg::COL_W-1:0]     bs_col;
  logic [7:0]                     fill_style;

  ttcs_ram #(
    .WIDTH(ttcs_pkg::CELL_W),
    .DEPTH(ttcs_pkg::CELL_COUNT)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_range    = (int'(row_q) < ttcs_pkg::SCREEN_ROWS) &&
                       (int'(col_q) < ttcs_pkg::SCREEN_COLUMNS);
  assign cursor_addr = ttcs_pkg::cell_addr(cursor_row, cursor_col);
  assign req_addr    = ttcs_pkg::cell_addr(ttcs_pkg::ROW_W'(row_q),
                                           ttcs_pkg::COL_W'(col_q));
  assign fill_style  = cmd.reset_fill ? ttcs_pkg::STYLE_RESET : text_style;

  always_comb begin
    bs_row = cursor_row;
    bs_col = cursor_col;
    if (cursor_col != '0) begin
      bs_col = cursor_col - 1'b1;
    end else if (cursor_row != '0) begin
      bs_row = cursor_row - 1'b1;
      bs_col = ttcs_pkg::COL_W'(ttcs_pkg::SCREEN_COLUMNS - 1);
    end
  end

  always_comb begin
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    sweep_next      = sweep;
    pend_next       = pend;
    waddr_d_next    = waddr_d;
    tab_left_next   = tab_left;
    cell_entry_next = cell_entry;
    ram_we          = 1'b0;
    ram_waddr       = cursor_addr;
    ram_wdata       = {text_style, ch_q};
    ram_raddr       = req_addr;
    case (cmd.op)
      ttcs_pkg::DP_NOP: begin
      end
      ttcs_pkg::DP_LATCH: begin
        tab_left_next   = '0;
        cell_entry_next = '0;
      end
      ttcs_pkg::DP_PUT_CHAR, ttcs_pkg::DP_PUT_SPACE: begin
        ram_we = 1'b1;
        if (cmd.op == ttcs_pkg::DP_PUT_SPACE) begin
          ram_wdata     = {text_style, ttcs_pkg::CH_SPACE};
          tab_left_next = tab_left - 1'b1;
        end
        // Passing the last column wraps within the same step.
        if (cursor_col == ttcs_pkg::COL_W'(ttcs_pkg::SCREEN_COLUMNS - 1)) begin
          cursor_col_next = '0;
          cursor_row_next = cursor_row + 1'b1;
        end else begin
          cursor_col_next = cursor_col + 1'b1;
        end
      end
      ttcs_pkg::DP_NEWLINE: begin
        cursor_col_next = '0;
        cursor_row_next = cursor_row + 1'b1;
      end
      ttcs_pkg::DP_RETURN: begin
        cursor_col_next = '0;
      end
      ttcs_pkg::DP_TAB_INIT: begin
        tab_left_next = ttcs_pkg::tab_gap(cursor_col);
      end
      ttcs_pkg::DP_BACKSPACE: begin
        // At the top-left corner nothing moves and nothing is erased.
        ram_we          = (cursor_col != '0) || (cursor_row != '0);
        ram_waddr       = ttcs_pkg::cell_addr(bs_row, bs_col);
        ram_wdata       = {text_style, ttcs_pkg::CH_SPACE};
        cursor_row_next = bs_row;
        cursor_col_next = bs_col;
      end
      ttcs_pkg::DP_SET_CURSOR: begin
        if (in_range) begin
          cursor_row_next = ttcs_pkg::ROW_W'(row_q);
          cursor_col_next = ttcs_pkg::COL_W'(col_q);
        end
      end
      ttcs_pkg::DP_READ_ISSUE: begin
        ram_raddr = req_addr;
      end
      ttcs_pkg::DP_READ_CAPTURE: begin
        cell_entry_next = in_range ? ram_rdata : '0;
      end
      ttcs_pkg::DP_CLEAR_INIT: begin
        sweep_next      = '0;
        cursor_row_next = '0;
        cursor_col_next = '0;
      end
      ttcs_pkg::DP_SCROLL_INIT: begin
        sweep_next = '0;
        pend_next  = 1'b0;
      end
      ttcs_pkg::DP_SCROLL_COPY: begin
        // Read one row ahead while writing the cell read in the last cycle.
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = waddr_d;
          ram_wdata = ram_rdata;
        end
        if (int'(sweep) < ttcs_pkg::SCROLL_CELLS) begin
          ram_raddr    = sweep + ttcs_pkg::ADDR_W'(ttcs_pkg::SCREEN_COLUMNS);
          pend_next    = 1'b1;
          waddr_d_next = sweep;
          sweep_next   = sweep + 1'b1;
        end else begin
          pend_next = 1'b0;
        end
      end
      ttcs_pkg::DP_SCROLL_END: begin
        cursor_row_next = ttcs_pkg::ROW_W'(ttcs_pkg::SCREEN_ROWS - 1);
        cursor_col_next = '0;
      end
      ttcs_pkg::DP_FILL_STYLE: begin
        ram_we    = 1'b1;
        ram_waddr = sweep;
        ram_wdata = {fill_style, ttcs_pkg::CH_SPACE};
        if (status.sweep_last) begin
          sweep_next = '0;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_style <= ttcs_pkg::STYLE_RESET;
      cursor_row <= '0;
      cursor_col <= '0;
      sweep      <= '0;
      pend       <= 1'b0;
      tab_left   <= '0;
    end else begin
      if (style_we) text_style <= style_data;
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
      sweep      <= sweep_next;
      pend       <= pend_next;
      tab_left   <= tab_left_next;
    end
  end

  always_ff @(posedge clk) begin
    waddr_d    <= waddr_d_next;
    cell_entry <= cell_entry_next;
    if (cmd.op == ttcs_pkg::DP_LATCH) begin
      op_q  <= ttcs_pkg::op_t'(op);
      ch_q  <= ch;
      row_q <= row;
      col_q <= col;
    end
  end

  always_comb begin
    case (ch_q)
      ttcs_pkg::CH_NEWLINE:   status.ch_kind = ttcs_pkg::CK_NEWLINE;
      ttcs_pkg::CH_RETURN:    status.ch_kind = ttcs_pkg::CK_RETURN;
      ttcs_pkg::CH_TAB:       status.ch_kind = ttcs_pkg::CK_TAB;
      ttcs_pkg::CH_BACKSPACE: status.ch_kind = ttcs_pkg::CK_BACKSPACE;
      default:                status.ch_kind = ttcs_pkg::CK_PRINT;
    endcase
  end

  assign status.op         = op_q;
  assign status.row_over   = (cursor_row == ttcs_pkg::ROW_W'(ttcs_pkg::SCREEN_ROWS));
  assign status.tab_busy   = (tab_left != '0);
  assign status.copy_done  = (sweep == ttcs_pkg::ADDR_W'(ttcs_pkg::SCROLL_CELLS)) && !pend;
  assign status.sweep_last = (sweep == ttcs_pkg::ADDR_W'(ttcs_pkg::CELL_COUNT - 1));

  assign cursor_row_out = 5'(cursor_row);
  assign cursor_col_out = 7'(cursor_col);

endmodule

FILE: hw/rtl/ttcs_ctrl.sv
// Controller state machine sequencing the datapath for each item.
module ttcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ttcs_pkg::dp_status_t status,
  output ttcs_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);

  ttcs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttcs_pkg::ST_RESET_FILL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.op         = ttcs_pkg::DP_NOP;
    cmd.reset_fill = 1'b0;
    busy           = 1'b1;
    done           = 1'b0;
    case (state)
      ttcs_pkg::ST_RESET_FILL: begin
        cmd.op         = ttcs_pkg::DP_FILL_STYLE;
        cmd.reset_fill = 1'b1;
        if (status.sweep_last) state_next = ttcs_pkg::ST_IDLE;
      end
      ttcs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op     = ttcs_pkg::DP_LATCH;
          state_next = ttcs_pkg::ST_DISPATCH;
        end
      end
      ttcs_pkg::ST_DISPATCH: begin
        case (status.op)
          ttcs_pkg::OP_PUT: begin
            case (status.ch_kind)
              ttcs_pkg::CK_NEWLINE: begin
                cmd.op     = ttcs_pkg::DP_NEWLINE;
                state_next = ttcs_pkg::ST_CHECK;
              end
              ttcs_pkg::CK_RETURN: begin
                cmd.op     = ttcs_pkg::DP_RETURN;
                state_next = ttcs_pkg::ST_FINISH;
              end
              ttcs_pkg::CK_TAB: begin
                cmd.op     = ttcs_pkg::DP_TAB_INIT;
                state_next = ttcs_pkg::ST_TAB;
              end
              ttcs_pkg::CK_BACKSPACE: begin
                cmd.op     = ttcs_pkg::DP_BACKSPACE;
                state_next = ttcs_pkg::ST_FINISH;
              end
              default: begin
                cmd.op     = ttcs_pkg::DP_PUT_CHAR;
                state_next = ttcs_pkg::ST_CHECK;
              end
            endcase
          end
          ttcs_pkg::OP_READ: begin
            cmd.op     = ttcs_pkg::DP_READ_ISSUE;
            state_next = ttcs_pkg::ST_READ_WAIT;
          end
          ttcs_pkg::OP_SET: begin
            cmd.op     = ttcs_pkg::DP_SET_CURSOR;
            state_next = ttcs_pkg::ST_FINISH;
          end
          default: begin
            cmd.op     = ttcs_pkg::DP_CLEAR_INIT;
            state_next = ttcs_pkg::ST_CLEAR;
          end
        endcase
      end
      ttcs_pkg::ST_TAB: begin
        cmd.op     = ttcs_pkg::DP_PUT_SPACE;
        state_next = ttcs_pkg::ST_CHECK;
      end
      ttcs_pkg::ST_CHECK: begin
        // A row past the bottom scrolls first; a pending tab then resumes.
        if (status.row_over) begin
          cmd.op     = ttcs_pkg::DP_SCROLL_INIT;
          state_next = ttcs_pkg::ST_SCROLL_COPY;
        end else if (status.tab_busy) begin
          state_next = ttcs_pkg::ST_TAB;
        end else begin
          state_next = ttcs_pkg::ST_FINISH;
        end
      end
      ttcs_pkg::ST_SCROLL_COPY: begin
        cmd.op = ttcs_pkg::DP_SCROLL_COPY;
        if (status.copy_done) state_next = ttcs_pkg::ST_SCROLL_BLANK;
      end
      ttcs_pkg::ST_SCROLL_BLANK: begin
        cmd.op = ttcs_pkg::DP_FILL_STYLE;
        if (status.sweep_last) state_next = ttcs_pkg::ST_SCROLL_END;
      end
      ttcs_pkg::ST_SCROLL_END: begin
        cmd.op     = ttcs_pkg::DP_SCROLL_END;
        state_next = ttcs_pkg::ST_CHECK;
      end
      ttcs_pkg::ST_CLEAR: begin
        cmd.op = ttcs_pkg::DP_FILL_STYLE;
        if (status.sweep_last) state_next = ttcs_pkg::ST_FINISH;
      end
      ttcs_pkg::ST_READ_WAIT: begin
        cmd.op     = ttcs_pkg::DP_READ_CAPTURE;
        state_next = ttcs_pkg::ST_FINISH;
      end
      ttcs_pkg::ST_FINISH: begin
        done       = 1'b1;
        state_next = ttcs_pkg::ST_IDLE;
      end
      default: begin
        state_next = ttcs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: test/text_terminal_cursor_scroll_tb.sv
// Self-checking testbench for the text terminal writer against a cell-level screen model.
`timescale 1ns / 1ps

module text_terminal_cursor_scroll_tb;
  import ttcs_pkg::*;

  typedef struct {
    op_t        op;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } term_item_t;

  typedef struct {
    logic [15:0] entry;
    logic [4:0]  crow;
    logic [6:0]  ccol;
  } term_view_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  op = OP_PUT;
  logic [7:0]  ch = 8'h00;
  logic [4:0]  row = 5'd0;
  logic [6:0]  col = 7'd0;
  logic        done;
  logic [15:0] cell_entry;
  logic [4:0]  cursor_row_out;
  logic [6:0]  cursor_col_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'h00;

  text_terminal_cursor_scroll u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .op             (op),
    .ch             (ch),
    .row            (row),
    .col            (col),
    .done           (done),
    .cell_entry     (cell_entry),
    .cursor_row_out (cursor_row_out),
    .cursor_col_out (cursor_col_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Screen model: cell store, cursor and style register.
  logic [15:0] screen_model [CELL_COUNT];
  int unsigned cur_row;
  int unsigned cur_col;
  logic [7:0]  style_reg;

  term_item_t  pending_items [$];
  term_view_t  expected_views [$];
  term_item_t  next_item;
  term_view_t  want;
  logic        item_taken = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          error_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void model_write(int unsigned r, int unsigned c, logic [7:0] chv);
    if (r < SCREEN_ROWS && c < SCREEN_COLUMNS)
      screen_model[r * SCREEN_COLUMNS + c] = {style_reg, chv};
  endfunction

  function automatic void model_fill();
    for (int i = 0; i < CELL_COUNT; i++) screen_model[i] = {style_reg, CH_SPACE};
  endfunction

  // Wrap past the last column, then scroll up one row past the last row.
  function automatic void model_settle();
    if (cur_col >= SCREEN_COLUMNS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= SCREEN_ROWS) begin
      for (int i = 0; i < SCROLL_CELLS; i++)
        screen_model[i] = screen_model[i + SCREEN_COLUMNS];
      for (int i = SCROLL_CELLS; i < CELL_COUNT; i++)
        screen_model[i] = {style_reg, CH_SPACE};
      cur_row = SCREEN_ROWS - 1;
      cur_col = 0;
    end
  endfunction

  function automatic void model_print(logic [7:0] chv);
    model_write(cur_row, cur_col, chv);
    cur_col++;
    model_settle();
  endfunction

  function automatic term_view_t model_apply(term_item_t it);
    term_view_t v;
    int unsigned n;
    v.entry = 16'h0000;
    case (it.op)
      OP_PUT: begin
        case (it.ch)
          CH_NEWLINE: begin
            cur_col = 0;
            cur_row++;
            model_settle();
          end
          CH_RETURN: begin
            cur_col = 0;
            model_settle();
          end
          CH_TAB: begin
            n = TAB_WIDTH - (cur_col % TAB_WIDTH);
            for (int i = 0; i < n; i++) model_print(CH_SPACE);
          end
          CH_BACKSPACE: begin
            if (cur_col > 0) begin
              cur_col--;
              model_write(cur_row, cur_col, CH_SPACE);
            end else if (cur_row > 0) begin
              cur_row--;
              cur_col = SCREEN_COLUMNS - 1;
              model_write(cur_row, cur_col, CH_SPACE);
            end
            model_settle();
          end
          default: model_print(it.ch);
        endcase
      end
      OP_READ: begin
        if (it.row < SCREEN_ROWS && it.col < SCREEN_COLUMNS)
          v.entry = screen_model[int'(it.row) * SCREEN_COLUMNS + int'(it.col)];
      end
      OP_SET: begin
        if (it.row < SCREEN_ROWS && it.col < SCREEN_COLUMNS) begin
          cur_row = 32'(it.row);
          cur_col = 32'(it.col);
        end
      end
      default: begin
        model_fill();
        cur_row = 0;
        cur_col = 0;
      end
    endcase
    v.crow = cur_row[4:0];
    v.ccol = cur_col[6:0];
    return v;
  endfunction

  function automatic term_item_t make_item(op_t o, logic [7:0] c, int r, int k);
    term_item_t it;
    it.op = o;
    it.ch = c;
    it.row = r[4:0];
    it.col = k[6:0];
    return it;
  endfunction

  // Position biased toward the bottom rows so that scrolls come often.
  function automatic term_item_t random_item();
    term_item_t it;
    int unsigned sel;
    int unsigned pos;
    sel = $urandom_range(0, 99);
    pos = $urandom_range(0, 99);
    it.ch = 8'($urandom_range(0, 255));
    if (pos < 45) begin
      it.row = 5'($urandom_range(SCREEN_ROWS - 5, SCREEN_ROWS - 1));
      it.col = 7'($urandom_range(0, SCREEN_COLUMNS - 1));
    end else if (pos < 75) begin
      it.row = 5'($urandom_range(0, SCREEN_ROWS - 1));
      it.col = 7'($urandom_range(0, SCREEN_COLUMNS - 1));
    end else begin
      it.row = 5'($urandom_range(0, 31));
      it.col = 7'($urandom_range(0, 127));
    end
    if (sel < 45) begin
      it.op = OP_PUT;
    end else if (sel < 55) begin
      it.op = OP_PUT;
      it.ch = CH_NEWLINE;
    end else if (sel < 60) begin
      it.op = OP_PUT;
      it.ch = CH_RETURN;
    end else if (sel < 67) begin
      it.op = OP_PUT;
      it.ch = CH_TAB;
    end else if (sel < 74) begin
      it.op = OP_PUT;
      it.ch = CH_BACKSPACE;
    end else if (sel < 86) begin
      it.op = OP_READ;
    end else if (sel < 97) begin
      it.op = OP_SET;
    end else begin
      it.op = OP_CLEAR;
    end
    return it;
  endfunction

  // Sender: bursts of items with random gaps; a refused item is held.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      start <= 1'b1;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_items.size() > 0) begin
      next_item = pending_items.pop_front();
      start <= 1'b1;
      op <= next_item.op;
      ch <= next_item.ch;
      row <= next_item.row;
      col <= next_item.col;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: checks each result, records accepted items and style writes.
  always @(posedge clk) begin
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      if (done) begin
        if (expected_views.size() == 0) begin
          $error("unexpected result: cell_entry %h row %0d col %0d",
                 cell_entry, cursor_row_out, cursor_col_out);
          error_count++;
        end else begin
          want = expected_views.pop_front();
          if (cell_entry !== want.entry) begin
            $error("cell_entry: expected %h, got %h", want.entry, cell_entry);
            error_count++;
          end
          if (cursor_row_out !== want.crow) begin
            $error("cursor_row_out: expected %0d, got %0d", want.crow, cursor_row_out);
            error_count++;
          end
          if (cursor_col_out !== want.ccol) begin
            $error("cursor_col_out: expected %0d, got %0d", want.ccol, cursor_col_out);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) style_reg = cfg_data;
      item_taken <= start && !busy;
      if (start && !busy)
        expected_views.push_back(model_apply(make_item(op_t'(op), ch, row, col)));
    end
  end

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_items.size() != 0 || start || busy || expected_views.size() != 0);
  endtask

  task automatic write_style(logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] styles [4];
    styles[0] = 8'h00;
    styles[1] = 8'hFF;
    styles[2] = 8'hA5;
    styles[3] = 8'($urandom_range(0, 255));
    style_reg = STYLE_RESET;
    cur_row = 0;
    cur_col = 0;
    model_fill();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    wait_quiet();

    pending_items.push_back(make_item(OP_READ, 8'h00, 0, 0));
    pending_items.push_back(make_item(OP_PUT, 8'h41, 0, 0));
    pending_items.push_back(make_item(OP_PUT, 8'h00, 0, 0));
    pending_items.push_back(make_item(OP_PUT, 8'hFF, 0, 0));
    // The first tab fills one column, the second starts on a tab stop.
    pending_items.push_back(make_item(OP_PUT, CH_TAB, 0, 0));
    pending_items.push_back(make_item(OP_PUT, CH_TAB, 0, 0));
    pending_items.push_back(make_item(OP_PUT, CH_RETURN, 0, 0));
    pending_items.push_back(make_item(OP_PUT, CH_BACKSPACE, 0, 0));
    pending_items.push_back(make_item(OP_PUT, CH_NEWLINE, 0, 0));
    pending_items.push_back(make_item(OP_PUT, CH_BACKSPACE, 0, 0));
    pending_items.push_back(make_item(OP_READ, 8'h00, 0, SCREEN_COLUMNS - 1));
    pending_items.push_back(make_item(OP_SET, 8'h00, SCREEN_ROWS - 1, SCREEN_COLUMNS - 1));
    pending_items.push_back(make_item(OP_PUT, 8'h5A, 0, 0));
    pending_items.push_back(make_item(OP_READ, 8'h00, SCREEN_ROWS - 2, SCREEN_COLUMNS - 1));
    pending_items.push_back(make_item(OP_SET, 8'h00, SCREEN_ROWS, 0));
    pending_items.push_back(make_item(OP_SET, 8'h00, 0, SCREEN_COLUMNS));
    pending_items.push_back(make_item(OP_SET, 8'hFF, 31, 127));
    pending_items.push_back(make_item(OP_READ, 8'h00, SCREEN_ROWS, 0));
    pending_items.push_back(make_item(OP_READ, 8'h00, 0, SCREEN_COLUMNS));
    pending_items.push_back(make_item(OP_READ, 8'hFF, 31, 127));
    pending_items.push_back(make_item(OP_SET, 8'h00, SCREEN_ROWS - 1, SCREEN_COLUMNS - 2));
    pending_items.push_back(make_item(OP_PUT, CH_TAB, 0, 0));
    pending_items.push_back(make_item(OP_PUT, CH_NEWLINE, 0, 0));
    pending_items.push_back(make_item(OP_CLEAR, 8'h00, 0, 0));
    pending_items.push_back(make_item(OP_READ, 8'h00, SCREEN_ROWS - 1, SCREEN_COLUMNS - 1));
    wait_quiet();

    for (int p = 0; p < 4; p++) begin
      write_style(styles[p]);
      for (int i = 0; i < 75; i++) pending_items.push_back(random_item());
      wait_quiet();
    end

    repeat (50) @(posedge clk);
    if (expected_views.size() != 0) begin
      $error("%0d results never arrived", expected_views.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
